// ----- sv/kgt_pkg.sv -----
// ----------------------------------------------------------------------------
// kgt_pkg: shared types and constants for the key glow table
// Entry and item layouts, cell operations, controller states and codes.
// ----------------------------------------------------------------------------
package kgt_pkg;

  localparam int TABLE_DEPTH   = 16;
  localparam int MERGE_DIVISOR = 4;

  localparam int STEP_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
  localparam int LIMIT_W = 14;
  localparam int DIST_W  = 17;
  localparam int COUNT_FIELD_W = 5;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION = 2'd1;

  localparam logic [7:0]  RADIUS_RESET   = 8'd40;
  localparam logic [15:0] DURATION_RESET = 16'd1000;

  localparam logic CMD_PRESS = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  localparam logic [1:0] ACT_REFRESH = 2'd0;
  localparam logic [1:0] ACT_APPEND  = 2'd1;
  localparam logic [1:0] ACT_REPLACE = 2'd2;
  localparam logic [1:0] ACT_TICK    = 2'd3;

  typedef struct packed {
    logic        cmd;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [1:0]               action;
    logic [COUNT_FIELD_W-1:0] live_count;
    logic [COUNT_FIELD_W-1:0] expired_count;
  } out_t;

  // One table entry as it travels down the row; drop marks a hole to squeeze out.
  typedef struct packed {
    logic        drop;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [31:0] t;
  } entry_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_ROTATE,
    CELL_COMPACT
  } cell_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_COMPACT
  } state_t;

endpackage

// ----- sv/kgt_cell.sv -----
// ----------------------------------------------------------------------------
// kgt_cell: one slot of the glow table
// Holds one entry and takes its upper neighbor's entry on rotate, or on compact when a hole lies at or below it.
// ----------------------------------------------------------------------------
module kgt_cell (
  input  logic              clk,
  input  kgt_pkg::cell_op_t op,
  input  logic              hole_in,
  input  kgt_pkg::entry_t   nxt_entry,
  output kgt_pkg::entry_t   entry,
  output logic              hole_out
);

  kgt_pkg::entry_t entry_r, entry_nxt;

  // A hole at or below this slot means this slot moves down during compaction.
  assign hole_out = hole_in | entry_r.drop;
  assign entry    = entry_r;

  always_comb begin
    entry_nxt = entry_r;
    unique case (op)
      kgt_pkg::CELL_HOLD:    entry_nxt = entry_r;
      kgt_pkg::CELL_ROTATE:  entry_nxt = nxt_entry;
      kgt_pkg::CELL_COMPACT: begin
        if (hole_out) begin
          entry_nxt = nxt_entry;
        end
      end
      default:               entry_nxt = entry_r;
    endcase
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// ----- sv/kgt_ctrl.sv -----
// ----------------------------------------------------------------------------
// kgt_ctrl: sequencer for the key glow table
// Examines the entry at the head of the row each cycle while scanning and feeds the tail.
// ----------------------------------------------------------------------------
module kgt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  kgt_pkg::in_t      in_data,
  input  logic [7:0]        merge_radius,
  input  logic [15:0]       glow_duration,
  input  kgt_pkg::entry_t   head,
  output logic              busy,
  output kgt_pkg::cell_op_t cell_op,
  output kgt_pkg::entry_t   tail,
  output logic              out_valid,
  output kgt_pkg::out_t     out_data
);

  kgt_pkg::state_t state_r, state_nxt;
  logic [kgt_pkg::STEP_W-1:0]  step_r, step_nxt;
  logic [kgt_pkg::CNT_W-1:0]   count_r, count_nxt;
  logic [kgt_pkg::CNT_W-1:0]   wr_r, wr_nxt;
  logic                        matched_r, matched_nxt;
  kgt_pkg::in_t                item_r;
  logic [kgt_pkg::LIMIT_W-1:0] limit_r;
  logic                        out_valid_r;
  kgt_pkg::out_t               out_data_r;

  logic                        done;
  logic [1:0]                  act;
  logic [kgt_pkg::CNT_W-1:0]   expired;
  logic                        live, last, near, fresh;
  logic signed [8:0]           dx, dy;
  logic [8:0]                  dx_neg, dy_neg;
  logic [7:0]                  adx, ady;
  logic [15:0]                 sqx, sqy;
  logic [kgt_pkg::DIST_W-1:0]  dist2;
  logic [31:0]                 age;
  logic [15:0]                 radius_sq;
  kgt_pkg::entry_t             press_entry;

  assign live = {1'b0, step_r} < count_r;
  assign last = step_r == kgt_pkg::STEP_W'(kgt_pkg::TABLE_DEPTH - 1);

  assign dx     = $signed({1'b0, item_r.pos_x}) - $signed({1'b0, head.x});
  assign dy     = $signed({1'b0, item_r.pos_y}) - $signed({1'b0, head.y});
  assign dx_neg = -dx;
  assign dy_neg = -dy;
  assign adx    = dx[8] ? dx_neg[7:0] : dx[7:0];
  assign ady    = dy[8] ? dy_neg[7:0] : dy[7:0];
  assign sqx    = 16'(adx) * 16'(adx);
  assign sqy    = 16'(ady) * 16'(ady);
  assign dist2  = kgt_pkg::DIST_W'(sqx) + kgt_pkg::DIST_W'(sqy);
  assign near   = dist2 < kgt_pkg::DIST_W'(limit_r);

  // Age is a wrapping difference, so a timestamp ahead of now looks very old.
  assign age    = item_r.now_ms - head.t;
  assign fresh  = age <= {16'b0, glow_duration};

  assign radius_sq = 16'(merge_radius) * 16'(merge_radius);

  always_comb begin
    press_entry      = '0;
    press_entry.x    = item_r.pos_x;
    press_entry.y    = item_r.pos_y;
    press_entry.t    = item_r.now_ms;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kgt_pkg::ST_IDLE;
      step_r      <= '0;
      count_r     <= '0;
      wr_r        <= '0;
      matched_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      count_r     <= count_nxt;
      wr_r        <= wr_nxt;
      matched_r   <= matched_nxt;
      out_valid_r <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == kgt_pkg::ST_IDLE && start) begin
      item_r  <= in_data;
      limit_r <= kgt_pkg::LIMIT_W'(radius_sq / kgt_pkg::MERGE_DIVISOR);
    end
    if (done) begin
      out_data_r.action        <= act;
      out_data_r.live_count    <= kgt_pkg::COUNT_FIELD_W'(count_nxt);
      out_data_r.expired_count <= kgt_pkg::COUNT_FIELD_W'(expired);
    end
  end

  always_comb begin
    state_nxt   = state_r;
    step_nxt    = step_r;
    count_nxt   = count_r;
    wr_nxt      = wr_r;
    matched_nxt = matched_r;
    cell_op     = kgt_pkg::CELL_HOLD;
    tail        = head;
    done        = 1'b0;
    act         = kgt_pkg::ACT_TICK;
    expired     = '0;
    unique case (state_r)
      kgt_pkg::ST_IDLE: begin
        if (start) begin
          state_nxt   = kgt_pkg::ST_SCAN;
          step_nxt    = '0;
          wr_nxt      = '0;
          matched_nxt = 1'b0;
        end
      end
      kgt_pkg::ST_SCAN: begin
        // The row turns once; every slot passes the head and returns to its place.
        cell_op   = kgt_pkg::CELL_ROTATE;
        step_nxt  = last ? '0 : step_r + 1'b1;
        tail.drop = 1'b0;
        if (item_r.cmd == kgt_pkg::CMD_PRESS) begin
          if (live && !matched_r && near) begin
            tail.t      = item_r.now_ms;
            matched_nxt = 1'b1;
          end else if ({1'b0, step_r} == count_r && !matched_r) begin
            // First free slot, reached only after every live entry was checked.
            tail = press_entry;
          end
          if (last) begin
            if (matched_nxt) begin
              state_nxt = kgt_pkg::ST_IDLE;
              done      = 1'b1;
              act       = kgt_pkg::ACT_REFRESH;
            end else if (count_r < kgt_pkg::CNT_W'(kgt_pkg::TABLE_DEPTH)) begin
              state_nxt = kgt_pkg::ST_IDLE;
              count_nxt = count_r + 1'b1;
              done      = 1'b1;
              act       = kgt_pkg::ACT_APPEND;
            end else begin
              state_nxt = kgt_pkg::ST_SHIFT;
            end
          end
        end else begin
          tail.drop = !(live && fresh);
          if (live && fresh) begin
            wr_nxt = wr_r + 1'b1;
          end
          if (last) begin
            state_nxt = kgt_pkg::ST_COMPACT;
          end
        end
      end
      kgt_pkg::ST_SHIFT: begin
        // Full table: one more step pushes the oldest out and the press in.
        cell_op   = kgt_pkg::CELL_ROTATE;
        tail      = press_entry;
        state_nxt = kgt_pkg::ST_IDLE;
        done      = 1'b1;
        act       = kgt_pkg::ACT_REPLACE;
      end
      kgt_pkg::ST_COMPACT: begin
        // Each cycle squeezes out the lowest marked hole.
        cell_op   = kgt_pkg::CELL_COMPACT;
        tail      = '0;
        tail.drop = 1'b1;
        step_nxt  = last ? '0 : step_r + 1'b1;
        if (last) begin
          state_nxt = kgt_pkg::ST_IDLE;
          count_nxt = wr_r;
          expired   = count_r - wr_r;
          done      = 1'b1;
          act       = kgt_pkg::ACT_TICK;
        end
      end
      default: begin
        state_nxt = kgt_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy      = state_r != kgt_pkg::ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= kgt_pkg::CNT_W'(kgt_pkg::TABLE_DEPTH))
    else $error("table count above depth");

  a_wr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kgt_pkg::ST_COMPACT) |-> (wr_r <= count_r))
    else $error("survivor count above table count");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) != kgt_pkg::ST_IDLE))
    else $error("result strobe without an item in work");

  a_start_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == kgt_pkg::ST_IDLE && start) |=> (state_r == kgt_pkg::ST_SCAN && step_r == '0))
    else $error("accepted item did not begin a scan");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");
`endif

endmodule

// ----- sv/keypress_glow_table.sv -----
// ----------------------------------------------------------------------------
// keypress_glow_table: ordered table of active key glows
// Presses refresh a nearby entry or append; ticks expire and compact entries.
// ----------------------------------------------------------------------------
// Order of work: a press is accepted, the row of 16 cells turns once, one slot
// past the head per cycle, and the registered result is strobed; when the table
// is full the oldest entry is dropped in a further shift step first. A tick turns
// the row the same way and then squeezes out expired slots in the compact state.
// A new item may be started in the cycle its predecessor's result is strobed.
// Reset (synchronous, rst_n low) empties the table and restores the registers.
module keypress_glow_table (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  kgt_pkg::in_t                       in_data,
  output logic                               out_valid,
  output kgt_pkg::out_t                      out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [kgt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kgt_pkg::CFG_DATA_W-1:0]     cfg_data
);

  logic [7:0]        radius_r;
  logic [15:0]       duration_r;
  kgt_pkg::cell_op_t cell_op;
  kgt_pkg::entry_t   tail;
  kgt_pkg::entry_t   cell_q [kgt_pkg::TABLE_DEPTH];
  logic              hole   [kgt_pkg::TABLE_DEPTH+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= kgt_pkg::RADIUS_RESET;
      duration_r <= kgt_pkg::DURATION_RESET;
    end else if (cfg_valid && cfg_ready) begin
      // Writes to indexes beyond the register list are dropped.
      unique case (cfg_index)
        kgt_pkg::REG_RADIUS: begin
          radius_r <= cfg_data[7:0];
        end
        kgt_pkg::REG_DURATION: begin
          duration_r <= cfg_data[15:0];
        end
        default: begin
        end
      endcase
    end
  end

  assign hole[0] = 1'b0;

  for (genvar k = 0; k < kgt_pkg::TABLE_DEPTH; k++) begin : g_cell
    kgt_pkg::entry_t nxt_entry;
    if (k == kgt_pkg::TABLE_DEPTH - 1) begin : g_tail
      assign nxt_entry = tail;
    end else begin : g_mid
      assign nxt_entry = cell_q[k+1];
    end
    kgt_cell u_cell (
      .clk       (clk),
      .op        (cell_op),
      .hole_in   (hole[k]),
      .nxt_entry (nxt_entry),
      .entry     (cell_q[k]),
      .hole_out  (hole[k+1])
    );
  end

  kgt_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .in_data       (in_data),
    .merge_radius  (radius_r),
    .glow_duration (duration_r),
    .head          (cell_q[0]),
    .busy          (busy),
    .cell_op       (cell_op),
    .tail          (tail),
    .out_valid     (out_valid),
    .out_data      (out_data)
  );

endmodule
